/* hw/rtl/sfp_pkg.sv */
// sfp_pkg: shared types and constants for the serial frame parser
// no dependencies; imported by sfp_store, sfp_ctrl and serial_frame_parser
`default_nettype none

package sfp_pkg;

  // widest payload memory address (payload depth is at most 64)
  localparam int MEM_AW = 6;

  // largest number of results one transaction may give
  localparam int MAX_RESULTS = 32;

  localparam logic [7:0] HOST_CODE_RST  = 8'h11;
  localparam logic [7:0] SLAVE_CODE_RST = 8'h16;
  localparam logic [5:0] MAX_LEN_RST    = 6'd18;

  typedef enum logic [1:0] {
    CFG_HOST_CODE  = 2'd0,
    CFG_SLAVE_CODE = 2'd1,
    CFG_MAX_LEN    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_LEN,
    PH_CMD,
    PH_DATA,
    PH_CS,
    PH_RD,
    PH_WR
  } phase_t;

  typedef enum logic [1:0] {
    ST_PAYLOAD = 2'd0,
    ST_LEN_ERR = 2'd1,
    ST_CS_ERR  = 2'd2
  } status_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [MEM_AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] host_code;
    logic [7:0] slave_code;
    logic [5:0] max_len;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/sfp_store.sv */
// sfp_store: payload byte memory, one write and one registered read per cycle
// depends on sfp_pkg (mem_req_t)
`default_nettype none

module sfp_store import sfp_pkg::*; #(
  parameter int PAYLOAD_DEPTH = 32
) (
  input  wire logic       clk,
  input  wire mem_req_t   req,
  output logic      [7:0] rdata
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  logic [7:0] mem [PAYLOAD_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr[AW-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hw/rtl/sfp_ctrl.sv */
// sfp_ctrl: frame parsing state machine, checksum, payload replay, result register
// depends on sfp_pkg; drives sfp_store through a mem_req_t
`default_nettype none

module sfp_ctrl import sfp_pkg::*; #(
  parameter int PAYLOAD_DEPTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [1:0] out_status,
  output logic            out_from_slave,
  output logic      [7:0] out_payload_byte,
  output logic      [4:0] out_byte_index,
  output logic            out_last,
  output mem_req_t        mem_req,
  input  wire logic [7:0] mem_rdata
);

  localparam int LIMIT = (PAYLOAD_DEPTH < MAX_RESULTS) ? PAYLOAD_DEPTH : MAX_RESULTS;
  localparam logic [5:0] LIMIT_C = 6'(LIMIT);

  phase_t     phase_r, phase_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [5:0] len_r, len_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [5:0] idx_r, idx_nxt;
  logic       dir_r, dir_nxt;

  logic       out_valid_r, out_valid_nxt;
  status_t    out_status_r, out_status_nxt;
  logic       out_slave_r, out_slave_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic [4:0] out_idx_r, out_idx_nxt;
  logic       out_last_r, out_last_nxt;

  logic       in_fire, out_free, may_emit;
  logic [5:0] lim;
  logic       len_bad, data_done, replay_last, start_hit;
  logic [7:0] sum_add;

  assign lim       = (cfg.max_len < LIMIT_C) ? cfg.max_len : LIMIT_C;
  assign len_bad   = in_rx_byte > {2'b00, lim};
  assign sum_add   = sum_r + in_rx_byte;
  assign data_done = ({1'b0, cnt_r} + 7'd2) >= {1'b0, len_r};
  assign replay_last = 6'(idx_r + 6'd1) == len_r;
  assign start_hit = (in_rx_byte == cfg.host_code) || (in_rx_byte == cfg.slave_code);

  // phases that can emit a result hold off input while the result register is full
  assign may_emit = (phase_r == PH_LEN) || (phase_r == PH_CMD) || (phase_r == PH_CS);
  assign in_stall = (phase_r == PH_RD) || (phase_r == PH_WR) || (out_valid_r && may_emit);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_START: if (in_fire && start_hit) phase_nxt = PH_LEN;
      PH_LEN:   if (in_fire) phase_nxt = len_bad ? PH_START : PH_CMD;
      PH_CMD: begin
        if (in_fire) begin
          priority if (len_r == 6'd0) phase_nxt = PH_START;
          else if (len_r == 6'd1)     phase_nxt = PH_CS;
          else                        phase_nxt = PH_DATA;
        end
      end
      PH_DATA:  if (in_fire && data_done) phase_nxt = PH_CS;
      PH_CS:    if (in_fire) phase_nxt = (sum_add == 8'd0) ? PH_RD : PH_START;
      PH_RD:    if (out_free) phase_nxt = PH_WR;
      PH_WR:    phase_nxt = replay_last ? PH_START : PH_RD;
      default:  phase_nxt = PH_START;
    endcase
  end

  // datapath and outputs
  always_comb begin
    sum_nxt        = sum_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    dir_nxt        = dir_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slave_nxt  = out_slave_r;
    out_byte_nxt   = out_byte_r;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;
    mem_req        = '0;
    unique case (phase_r)
      PH_START: begin
        if (in_fire) begin
          priority if (in_rx_byte == cfg.host_code) begin
            dir_nxt = 1'b0;
            sum_nxt = in_rx_byte;
          end else if (in_rx_byte == cfg.slave_code) begin
            dir_nxt = 1'b1;
            sum_nxt = in_rx_byte;
          end else begin
            sum_nxt = 8'd0;
          end
        end
      end
      PH_LEN: begin
        if (in_fire) begin
          if (len_bad) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_LEN_ERR;
            out_slave_nxt  = dir_r;
            out_byte_nxt   = 8'd0;
            out_idx_nxt    = 5'd0;
            out_last_nxt   = 1'b1;
            sum_nxt        = 8'd0;
            cnt_nxt        = 6'd0;
          end else begin
            len_nxt = in_rx_byte[5:0];
            sum_nxt = sum_add;
          end
        end
      end
      PH_CMD: begin
        if (in_fire) begin
          if (len_r == 6'd0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_LEN_ERR;
            out_slave_nxt  = dir_r;
            out_byte_nxt   = 8'd0;
            out_idx_nxt    = 5'd0;
            out_last_nxt   = 1'b1;
            sum_nxt        = 8'd0;
            cnt_nxt        = 6'd0;
          end else begin
            sum_nxt       = sum_add;
            cnt_nxt       = 6'd0;
            mem_req.we    = 1'b1;
            mem_req.waddr = '0;
            mem_req.wdata = in_rx_byte;
          end
        end
      end
      PH_DATA: begin
        if (in_fire) begin
          sum_nxt       = sum_add;
          cnt_nxt       = 6'(cnt_r + 6'd1);
          mem_req.we    = 1'b1;
          mem_req.waddr = MEM_AW'(cnt_r + 6'd1);
          mem_req.wdata = in_rx_byte;
        end
      end
      PH_CS: begin
        if (in_fire) begin
          sum_nxt = 8'd0;
          cnt_nxt = 6'd0;
          idx_nxt = 6'd0;
          if (sum_add != 8'd0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_CS_ERR;
            out_slave_nxt  = dir_r;
            out_byte_nxt   = 8'd0;
            out_idx_nxt    = 5'd0;
            out_last_nxt   = 1'b1;
          end
        end
      end
      PH_RD: begin
        // read only when the result register is free by the next edge
        if (out_free) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = MEM_AW'(idx_r);
        end
      end
      PH_WR: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_PAYLOAD;
        out_slave_nxt  = dir_r;
        out_byte_nxt   = mem_rdata;
        out_idx_nxt    = idx_r[4:0];
        out_last_nxt   = replay_last;
        idx_nxt        = 6'(idx_r + 6'd1);
      end
      default: begin
        sum_nxt = 8'd0;
        cnt_nxt = 6'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      sum_r       <= 8'd0;
      len_r       <= 6'd0;
      cnt_r       <= 6'd0;
      idx_r       <= 6'd0;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      sum_r       <= sum_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_slave_r  <= out_slave_nxt;
    out_byte_r   <= out_byte_nxt;
    out_idx_r    <= out_idx_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_from_slave   = out_slave_r;
  assign out_payload_byte = out_byte_r;
  assign out_byte_index   = out_idx_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  a_wait_only_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && out_valid_r) |-> (phase_r == PH_START || phase_r == PH_DATA))
    else $error("input taken in a result phase while result pending");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WR) |-> !out_valid_r)
    else $error("replay load with result register occupied");

  a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_PAYLOAD) |-> ({1'b0, out_idx_r} < len_r))
    else $error("payload index beyond frame length");

  a_good_cs_replays: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CS && in_fire && sum_add == 8'd0) |=> (phase_r == PH_RD))
    else $error("good checksum did not start replay");
`endif

endmodule

`default_nettype wire

/* hw/rtl/serial_frame_parser.sv */
// serial_frame_parser: top level; configuration registers, parser and payload memory
// depends on sfp_pkg, sfp_store, sfp_ctrl
//
// Usage: one received byte per input transaction on in_rx_byte (in_valid/in_stall).
// Results leave on the out_ channel (out_valid/out_stall) from one output register.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 host start code,
// 1 slave start code, 2 max length); the user writes only while the parser is idle,
// which the block itself does not enforce. Throughput: a byte in the start code
// hunt or the data phase is taken every cycle, also while a result waits in the
// output register. A length byte, command byte or checksum byte is held off while a
// result waits. A bad length or checksum gives one error result in the cycle after
// the byte. A good checksum byte replays the L stored payload bytes from the payload
// memory, each through a read state and an output load state; the read state waits
// until the output register is free. No input is taken during the replay.
// Reset (rst_n low, synchronous): parser hunts for a start code, sum cleared, output
// empty, configuration back to 0x11, 0x16 and 18. The payload memory is not cleared.
// A stalled receiver keeps the current result steady; the replay waits for it.
`default_nettype none

module serial_frame_parser import sfp_pkg::*; #(
  parameter int PAYLOAD_DEPTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [1:0] out_status,
  output logic            out_from_slave,
  output logic      [7:0] out_payload_byte,
  output logic      [4:0] out_byte_index,
  output logic            out_last
);

  cfg_t     cfg_r, cfg_nxt;
  mem_req_t mem_req;
  logic [7:0] mem_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOST_CODE:  cfg_nxt.host_code  = cfg_wdata;
        CFG_SLAVE_CODE: cfg_nxt.slave_code = cfg_wdata;
        CFG_MAX_LEN:    cfg_nxt.max_len    = cfg_wdata[5:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.host_code  <= HOST_CODE_RST;
      cfg_r.slave_code <= SLAVE_CODE_RST;
      cfg_r.max_len    <= MAX_LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sfp_ctrl #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_from_slave   (out_from_slave),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last),
    .mem_req          (mem_req),
    .mem_rdata        (mem_rdata)
  );

  sfp_store #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
